// ===== rtl/core/tnnh_pkg.sv =====
package tnnh_pkg;

    localparam int ID_W       = 16;
    localparam int MAX_LEVELS = 4;
    localparam int SIZE_REGS  = 4;
    localparam int LVL_W      = 2;
    localparam int CNT_W      = 3;
    localparam int OFFS_W     = 18;
    localparam int ADDR_W     = 5;

    localparam logic [2:0] REG_LEVEL_COUNT = 3'd0;
    localparam logic [2:0] REG_LEAF_SIZE   = 3'd1;
    localparam logic [2:0] REG_SECOND_SIZE = 3'd2;
    localparam logic [2:0] REG_THIRD_SIZE  = 3'd3;
    localparam logic [2:0] REG_FOURTH_SIZE = 3'd4;

    typedef enum logic [1:0] {
        DIR_UP         = 2'd0,
        DIR_HORIZONTAL = 2'd1,
        DIR_DOWN       = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        ST_ROUTED       = 2'd0,
        ST_AT_DEST      = 2'd1,
        ST_OUT_OF_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        DIV_FAN = 2'd0,
        DIV_A   = 2'd1,
        DIV_B   = 2'd2
    } div_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_FAN,
        S_FAN_WAIT,
        S_RANGE,
        S_CLIMB,
        S_CLIMB_WAIT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic    load_in;
        logic    fan_init;
        logic    div_start;
        div_op_t div_op;
        logic    div_store;
        logic    set_err;
        logic    set_same;
        logic    setup;
        logic    lt_inc;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic early_bad;
        logic fan_more;
        logic fan_bad;
        logic range_bad;
        logic same;
        logic need_a;
        logic need_b;
        logic can_climb;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/core/tnnh_div.sv =====
module tnnh_div
    import tnnh_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [ID_W-1:0] num,
    input  logic [ID_W-1:0] den,
    output logic            busy,
    output logic            done,
    output logic [ID_W-1:0] quo,
    output logic [ID_W-1:0] rem
);

    localparam int DCNT_W = $clog2(ID_W + 1);

    logic [ID_W-1:0]   quo_reg, quo_next;
    logic [ID_W-1:0]   rem_reg, rem_next;
    logic [ID_W-1:0]   den_reg, den_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ID_W:0]     trial;

    // One quotient bit per cycle, restoring form.
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[ID_W-1]};
        if (start) begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = DCNT_W'(ID_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = ID_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[ID_W-2:0], 1'b1};
            end else begin
                rem_next = trial[ID_W-1:0];
                quo_next = {quo_reg[ID_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/core/tnnh_ctrl.sv =====
module tnnh_ctrl
    import tnnh_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_op = DIV_FAN;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.fan_init = 1'b1;
                if (sts.early_bad) begin
                    cmd.set_err = 1'b1;
                    state_next  = S_FINISH;
                end else begin
                    state_next = S_FAN;
                end
            end
            S_FAN: begin
                if (sts.fan_bad) begin
                    cmd.set_err = 1'b1;
                    state_next  = S_FINISH;
                end else if (sts.fan_more) begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = DIV_FAN;
                    state_next    = S_FAN_WAIT;
                end else begin
                    state_next = S_RANGE;
                end
            end
            S_FAN_WAIT: begin
                if (sts.div_done) begin
                    cmd.div_store = 1'b1;
                    state_next    = S_FAN;
                end
            end
            S_RANGE: begin
                if (sts.range_bad) begin
                    cmd.set_err = 1'b1;
                    state_next  = S_FINISH;
                end else if (sts.same) begin
                    cmd.set_same = 1'b1;
                    state_next   = S_FINISH;
                end else begin
                    cmd.setup  = 1'b1;
                    state_next = S_CLIMB;
                end
            end
            S_CLIMB: begin
                if (sts.need_a) begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = DIV_A;
                    state_next    = S_CLIMB_WAIT;
                end else if (sts.need_b) begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = DIV_B;
                    state_next    = S_CLIMB_WAIT;
                end else if (sts.can_climb) begin
                    cmd.lt_inc = 1'b1;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_CLIMB_WAIT: begin
                if (sts.div_done) begin
                    cmd.div_store = 1'b1;
                    state_next    = S_CLIMB;
                end
            end
            S_FINISH: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/tnnh_dp.sv =====
module tnnh_dp
    import tnnh_pkg::*;
(
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [CNT_W-1:0]               cfg_level_count,
    input  logic [SIZE_REGS-1:0][ID_W-1:0] cfg_size,
    input  logic [2*ID_W-1:0]              s_tdata,
    input  cmd_t                           cmd,
    output sts_t                           sts,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [2*ID_W-1:0]              m_tdata,
    output logic [3:0]                     m_tuser
);

    logic [ID_W-1:0]   cur_reg, dst_reg;
    logic [OFFS_W-1:0] offs_reg [SIZE_REGS+1];
    logic [OFFS_W-1:0] offs_next [SIZE_REGS+1];
    logic [ID_W-1:0]   fsh_reg [SIZE_REGS];
    logic [ID_W-1:0]   fan_reg [SIZE_REGS];
    logic [LVL_W-1:0]  fan_l_reg;
    logic              fan_bad_reg;
    div_op_t           op_reg;
    logic [ID_W-1:0]   a_reg, b_reg, parent_reg, child_reg, prem_reg;
    logic [LVL_W-1:0]  la_reg, lb_reg, lt_reg, lc_reg;
    status_t           kind_reg;
    logic              out_valid_reg;
    logic [ID_W-1:0]   out_nxt_reg, out_pos_reg;
    dir_t              out_dir_reg;
    status_t           out_st_reg;

    logic              n_ok;
    logic [LVL_W-1:0]  root;
    logic [OFFS_W-1:0] total;
    logic [LVL_W-1:0]  lc, ld;
    logic [ID_W-1:0]   div_num, div_den, div_quo, div_rem;
    logic              div_busy, div_done;
    logic [OFFS_W-1:0] nxt_wide;
    logic [ID_W-1:0]   res_nxt, res_pos;
    dir_t              res_dir;

    function automatic logic [LVL_W-1:0] level_of(input logic [ID_W-1:0] id,
                                                  input logic [CNT_W-1:0] n,
                                                  input logic [OFFS_W-1:0] o1,
                                                  input logic [OFFS_W-1:0] o2,
                                                  input logic [OFFS_W-1:0] o3);
        logic [LVL_W-1:0] l;
        l = '0;
        if (n > CNT_W'(1) && {2'b00, id} >= o1) l = LVL_W'(1);
        if (n > CNT_W'(2) && {2'b00, id} >= o2) l = LVL_W'(2);
        if (n > CNT_W'(3) && {2'b00, id} >= o3) l = LVL_W'(3);
        return l;
    endfunction

    assign n_ok = (cfg_level_count >= CNT_W'(1)) && (cfg_level_count <= CNT_W'(MAX_LEVELS));
    assign root = LVL_W'(cfg_level_count - CNT_W'(1));

    // Level start offsets follow the sizes; they settle long before they are read.
    always_comb begin
        offs_next[0] = '0;
        for (int l = 1; l <= SIZE_REGS; l++) begin
            offs_next[l] = offs_next[l-1] + OFFS_W'(cfg_size[l-1]);
        end
    end

    always_comb begin
        case (cfg_level_count)
            CNT_W'(1): total = offs_reg[1];
            CNT_W'(2): total = offs_reg[2];
            CNT_W'(3): total = offs_reg[3];
            CNT_W'(4): total = offs_reg[4];
            default:   total = '0;
        endcase
    end

    assign lc = level_of(cur_reg, cfg_level_count, offs_reg[1], offs_reg[2], offs_reg[3]);
    assign ld = level_of(dst_reg, cfg_level_count, offs_reg[1], offs_reg[2], offs_reg[3]);

    always_comb begin
        sts.early_bad = !n_ok;
        for (int l = 0; l < SIZE_REGS; l++) begin
            if (CNT_W'(l) < cfg_level_count && cfg_size[l] == '0) begin
                sts.early_bad = 1'b1;
            end
        end
        sts.fan_more  = ({1'b0, fan_l_reg} + CNT_W'(1)) < cfg_level_count;
        sts.fan_bad   = fan_bad_reg;
        sts.range_bad = (total > OFFS_W'(1 << ID_W)) || ({2'b00, cur_reg} >= total)
                        || ({2'b00, dst_reg} >= total);
        sts.same      = cur_reg == dst_reg;
        sts.need_a    = la_reg < lt_reg;
        sts.need_b    = lb_reg < lt_reg;
        sts.can_climb = (a_reg != b_reg) && (lt_reg < root);
        sts.div_done  = div_done;
        sts.out_free  = !out_valid_reg || m_tready;
    end

    // The shared divider serves fanouts first and then both ancestor climbs.
    always_comb begin
        case (cmd.div_op)
            DIV_A: begin
                div_num = a_reg;
                div_den = fan_reg[la_reg];
            end
            DIV_B: begin
                div_num = b_reg;
                div_den = fan_reg[lb_reg];
            end
            default: begin
                div_num = fsh_reg[0];
                div_den = fsh_reg[1];
            end
        endcase
    end

    tnnh_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    always_comb begin
        nxt_wide = '0;
        res_dir  = DIR_UP;
        res_pos  = '0;
        case (kind_reg)
            ST_ROUTED: begin
                if (lt_reg != lc_reg) begin
                    nxt_wide = offs_reg[{1'b0, lc_reg} + CNT_W'(1)] + OFFS_W'(parent_reg);
                end else if (a_reg != b_reg) begin
                    nxt_wide = offs_reg[{1'b0, root}] + OFFS_W'(b_reg);
                    res_dir  = DIR_HORIZONTAL;
                    res_pos  = b_reg;
                end else begin
                    nxt_wide = offs_reg[{1'b0, lc_reg - LVL_W'(1)}] + OFFS_W'(child_reg);
                    res_dir  = DIR_DOWN;
                    res_pos  = prem_reg;
                end
            end
            ST_AT_DEST: nxt_wide = OFFS_W'(cur_reg);
            default:    nxt_wide = '0;
        endcase
        res_nxt = nxt_wide[ID_W-1:0];
    end

    always_ff @(posedge aclk) begin
        for (int l = 0; l <= SIZE_REGS; l++) begin
            offs_reg[l] <= offs_next[l];
        end
        if (cmd.load_in) begin
            cur_reg <= s_tdata[ID_W-1:0];
            dst_reg <= s_tdata[2*ID_W-1:ID_W];
        end
        if (cmd.fan_init) begin
            for (int l = 0; l < SIZE_REGS; l++) begin
                fsh_reg[l] <= cfg_size[l];
            end
            fan_l_reg   <= '0;
            fan_bad_reg <= 1'b0;
        end
        if (cmd.div_start) begin
            op_reg <= cmd.div_op;
        end
        if (cmd.div_store) begin
            case (op_reg)
                DIV_A: begin
                    if (la_reg == lc_reg) parent_reg <= div_quo;
                    a_reg  <= div_quo;
                    la_reg <= la_reg + LVL_W'(1);
                end
                DIV_B: begin
                    if ({1'b0, lb_reg} + CNT_W'(1) == {1'b0, lc_reg}) begin
                        child_reg <= b_reg;
                        prem_reg  <= div_rem;
                    end
                    b_reg  <= div_quo;
                    lb_reg <= lb_reg + LVL_W'(1);
                end
                default: begin
                    fan_reg[fan_l_reg] <= div_quo;
                    if (div_rem != '0) fan_bad_reg <= 1'b1;
                    fan_l_reg <= fan_l_reg + LVL_W'(1);
                    for (int l = 0; l < SIZE_REGS - 1; l++) begin
                        fsh_reg[l] <= fsh_reg[l+1];
                    end
                end
            endcase
        end
        if (cmd.setup) begin
            lc_reg   <= lc;
            la_reg   <= lc;
            lb_reg   <= ld;
            lt_reg   <= (lc > ld) ? lc : ld;
            a_reg    <= ID_W'({2'b00, cur_reg} - offs_reg[{1'b0, lc}]);
            b_reg    <= ID_W'({2'b00, dst_reg} - offs_reg[{1'b0, ld}]);
            kind_reg <= ST_ROUTED;
        end
        if (cmd.set_err)  kind_reg <= ST_OUT_OF_RANGE;
        if (cmd.set_same) kind_reg <= ST_AT_DEST;
        if (cmd.lt_inc)   lt_reg <= lt_reg + LVL_W'(1);
        if (cmd.out_load) begin
            out_nxt_reg <= res_nxt;
            out_dir_reg <= res_dir;
            out_pos_reg <= res_pos;
            out_st_reg  <= kind_reg;
        end
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pos_reg, out_nxt_reg};
    assign m_tuser  = {out_st_reg, out_dir_reg};

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before it was taken");

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !div_busy)
        else $error("divider started while busy");

    a_store_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_store |-> div_done)
        else $error("quotient stored before divider finished");

    a_down_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && kind_reg == ST_ROUTED && lt_reg == lc_reg && a_reg == b_reg)
        |-> lc_reg != '0)
        else $error("down route taken from the leaf level");

endmodule

// ===== rtl/core/tree_network_next_hop.sv =====
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  current_router, destination_router
// m_        out        m_tvalid/m_tready  next_router, port_position; tuser: direction, status
// cfg       in         APB write/read     level_count, four level sizes
//
// One item at a time. An item whose configuration fails the first checks makes no divider
// pass; otherwise every fanout and every ancestor step is a pass through the single shared
// divider, up to nine passes per item at four levels.
// Reset is synchronous and active low; it clears the controller, divider and output valid.
// A finished result waits in the output register; the next item is taken meanwhile and
// its result waits until the register is free.
module tree_network_next_hop
    import tnnh_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // current_router, destination_router
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // next_router, port_position
    output logic [3:0]        m_tuser,   // port_direction, route_status
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [CNT_W-1:0]               level_count_reg;
    logic [SIZE_REGS-1:0][ID_W-1:0] size_reg;
    logic                           wr_en;
    cmd_t                           cmd;
    sts_t                           sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_count_reg <= CNT_W'(1);
            for (int l = 0; l < SIZE_REGS; l++) begin
                size_reg[l] <= ID_W'(1);
            end
        end else if (wr_en) begin
            case (paddr[4:2])
                REG_LEVEL_COUNT: level_count_reg <= pwdata[CNT_W-1:0];
                REG_LEAF_SIZE:   size_reg[0] <= pwdata[ID_W-1:0];
                REG_SECOND_SIZE: size_reg[1] <= pwdata[ID_W-1:0];
                REG_THIRD_SIZE:  size_reg[2] <= pwdata[ID_W-1:0];
                REG_FOURTH_SIZE: size_reg[3] <= pwdata[ID_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_LEVEL_COUNT: prdata = 32'(level_count_reg);
            REG_LEAF_SIZE:   prdata = 32'(size_reg[0]);
            REG_SECOND_SIZE: prdata = 32'(size_reg[1]);
            REG_THIRD_SIZE:  prdata = 32'(size_reg[2]);
            REG_FOURTH_SIZE: prdata = 32'(size_reg[3]);
            default:         prdata = '0;
        endcase
    end

    tnnh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tnnh_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_level_count (level_count_reg),
        .cfg_size        (size_reg),
        .s_tdata         (s_tdata),
        .cmd             (cmd),
        .sts             (sts),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser)
    );

endmodule

// ===== verif/tree_network_next_hop_checker.sv =====
`timescale 1ns / 1ps

module tree_network_next_hop_checker
    import tnnh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [3:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          hops_pending
);

    typedef struct packed {
        logic [15:0] next_router;
        dir_t        port_direction;
        logic [15:0] port_position;
        status_t     route_status;
    } hop_t;

    logic [2:0]  levels_cfg;
    logic [15:0] size_cfg [SIZE_REGS];
    hop_t        hop_queue [$];

    assign hops_pending = hop_queue.size();

    function automatic hop_t route_hop(logic [15:0] cur, logic [15:0] dst);
        hop_t h;
        int unsigned n, base[SIZE_REGS+1], sz[SIZE_REGS];
        int unsigned lc, ld, lt, a, b, root, f, child;
        longint unsigned total;
        bit ok;
        h = '{16'd0, DIR_UP, 16'd0, ST_ROUTED};
        for (int i = 0; i < SIZE_REGS; i++) sz[i] = 32'(size_cfg[i]);
        n = (levels_cfg >= 1 && levels_cfg <= MAX_LEVELS) ? 32'(levels_cfg) : 0;
        ok = (n != 0);
        total = 0;
        for (int l = 0; l < n && ok; l++) begin
            if (sz[l] == 0) ok = 0;
            else if (l + 1 < n && (sz[l+1] == 0 || sz[l] % sz[l+1] != 0)) ok = 0;
            base[l] = 32'(total);
            total += sz[l];
        end
        if (ok) base[n] = 32'(total);
        if (!ok || total > 65536 || cur >= total || dst >= total) begin
            h.route_status = ST_OUT_OF_RANGE;
            return h;
        end
        if (cur == dst) begin
            h.next_router = cur;
            h.route_status = ST_AT_DEST;
            return h;
        end
        root = n - 1;
        lc = 0;
        while (lc + 1 < n && cur >= base[lc+1]) lc++;
        ld = 0;
        while (ld + 1 < n && dst >= base[ld+1]) ld++;
        lt = lc > ld ? lc : ld;
        a = (cur - base[lc]) / (sz[lc] / sz[lt]);
        b = (dst - base[ld]) / (sz[ld] / sz[lt]);
        while (a != b && lt < root) begin
            f = sz[lt] / sz[lt+1];
            a /= f;
            b /= f;
            lt++;
        end
        if (lt != lc) begin
            h.next_router = 16'(base[lc+1] + (cur - base[lc]) / (sz[lc] / sz[lc+1]));
        end else if (a != b) begin
            h.next_router = 16'(base[root] + b);
            h.port_direction = DIR_HORIZONTAL;
            h.port_position = 16'(b);
        end else begin
            // The current router is the common ancestor, so step down one level.
            f = sz[lc-1] / sz[lc];
            child = (dst - base[ld]) / (sz[ld] / sz[lc-1]);
            h.next_router = 16'(base[lc-1] + child);
            h.port_direction = DIR_DOWN;
            h.port_position = 16'(child - a * f);
        end
        return h;
    endfunction

    always @(posedge aclk) begin
        hop_t e;
        int   errs;
        if (!aresetn) begin
            levels_cfg <= 3'd1;
            for (int i = 0; i < SIZE_REGS; i++) size_cfg[i] <= 16'd1;
            hop_queue.delete();
            fail_count <= 0;
        end else begin
            errs = 0;
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_LEVEL_COUNT: levels_cfg <= pwdata[2:0];
                    REG_LEAF_SIZE:   size_cfg[0] <= pwdata[15:0];
                    REG_SECOND_SIZE: size_cfg[1] <= pwdata[15:0];
                    REG_THIRD_SIZE:  size_cfg[2] <= pwdata[15:0];
                    REG_FOURTH_SIZE: size_cfg[3] <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                hop_queue = {hop_queue, route_hop(s_tdata[15:0], s_tdata[31:16])};
            if (m_tvalid && m_tready) begin
                if (hop_queue.size() == 0) begin
                    $error("result item with no expectation: %h %h", m_tdata, m_tuser);
                    errs++;
                end else begin
                    e = hop_queue.pop_front();
                    if (m_tdata[15:0] !== e.next_router) begin
                        $error("next_router: expected %0d, got %0d", e.next_router,
                               m_tdata[15:0]);
                        errs++;
                    end
                    if (m_tdata[31:16] !== e.port_position) begin
                        $error("port_position: expected %0d, got %0d", e.port_position,
                               m_tdata[31:16]);
                        errs++;
                    end
                    if (m_tuser[1:0] !== e.port_direction) begin
                        $error("port_direction: expected %0d, got %0d", e.port_direction,
                               m_tuser[1:0]);
                        errs++;
                    end
                    if (m_tuser[3:2] !== e.route_status) begin
                        $error("route_status: expected %0d, got %0d", e.route_status,
                               m_tuser[3:2]);
                        errs++;
                    end
                end
            end
            if (errs != 0) fail_count <= fail_count + errs;
        end
    end

endmodule

// ===== verif/tree_network_next_hop_tb.sv =====
`timescale 1ns / 1ps

module tree_network_next_hop_tb;
    import tnnh_pkg::*;

    logic              aclk = 0;
    logic              aresetn = 0;
    logic              s_tvalid = 0, s_tready;
    logic [31:0]       s_tdata = '0;
    logic              m_tvalid, m_tready = 0;
    logic [31:0]       m_tdata;   // next_router, port_position
    logic [3:0]        m_tuser;   // port_direction, route_status
    logic              psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0, prdata;
    logic              pready;
    int                fail_count, hops_pending;

    int sender_idle_pct = 31, receiver_idle_pct = 61;
    bit sink_hold = 0;
    int quiet_cycles = 0;
    int tot_routers;
    int unsigned cfg_sizes [SIZE_REGS];
    int unsigned cfg_levels;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    tree_network_next_hop dut (.*);

    tree_network_next_hop_checker checker_i (.*);

    // Receiver: random stalls plus a long hold-off when asked.
    always @(negedge aclk) begin
        if (sink_hold) m_tready <= 0;
        else m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("tree_network_next_hop regression: fail");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge aclk);
        penable <= 1;
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic drain_hops();
        while (hops_pending != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    // Writes a configuration; sizes are leaf first.
    task automatic set_tree(int unsigned lv, int unsigned s0, int unsigned s1,
                            int unsigned s2, int unsigned s3);
        drain_hops();
        cfg_levels = lv;
        cfg_sizes[0] = s0; cfg_sizes[1] = s1; cfg_sizes[2] = s2; cfg_sizes[3] = s3;
        reg_write(REG_LEVEL_COUNT, lv);
        reg_write(REG_LEAF_SIZE, s0);
        reg_write(REG_SECOND_SIZE, s1);
        reg_write(REG_THIRD_SIZE, s2);
        reg_write(REG_FOURTH_SIZE, s3);
        tot_routers = 0;
        for (int l = 0; l < lv && l < SIZE_REGS; l++) tot_routers += cfg_sizes[l];
    endtask

    task automatic send_route(logic [15:0] cur, logic [15:0] dst);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) @(negedge aclk);
        s_tvalid <= 1;
        s_tdata <= {dst, cur};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        s_tvalid <= 0;
    endtask

    function automatic logic [15:0] pick_router();
        int r;
        r = $urandom_range(99);
        if (r < 4) return 16'($urandom);
        if (r < 8) return 16'(tot_routers);
        if (r < 12 && tot_routers > 0) return 16'(tot_routers - 1);
        return 16'($urandom_range(tot_routers > 0 ? tot_routers - 1 : 0));
    endfunction

    task automatic random_batch(int count);
        logic [15:0] c;
        for (int i = 0; i < count; i++) begin
            c = pick_router();
            send_route(c, ($urandom_range(9) == 0) ? c : pick_router());
        end
    endtask

    task automatic random_tree();
        int unsigned lv, f1, f2, f3, top;
        lv = $urandom_range(1, 4);
        top = $urandom_range(1, 6);
        f3 = $urandom_range(1, 4);
        f2 = $urandom_range(1, 4);
        f1 = $urandom_range(1, 5);
        case (lv)
            1: set_tree(1, $urandom_range(1, 40), $urandom, $urandom, $urandom);
            2: set_tree(2, top * f1, top, $urandom, $urandom);
            3: set_tree(3, top * f2 * f1, top * f2, top, $urandom);
            default: set_tree(4, top * f3 * f2 * f1, top * f3 * f2, top * f3, top);
        endcase
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1;

        // Reset configuration: a single router.
        send_route(0, 0);
        send_route(0, 1);
        set_tree(4, 24, 12, 4, 2);
        send_route(0, 1);      // sideways? no: up to the parent
        send_route(0, 0);
        send_route(0, 41);     // leaf to root
        send_route(40, 0);     // root down to a leaf
        send_route(40, 41);    // sideways at the root
        send_route(36, 24);    // down from level 2
        send_route(23, 0);     // leaves in different subtrees
        send_route(41, 42);    // out of range
        send_route(16'hffff, 0);
        send_route(0, 16'hffff);
        set_tree(2, 6, 4, 1, 1);   // fanout not dividing
        send_route(0, 1);
        set_tree(0, 1, 1, 1, 1);   // zero levels
        send_route(0, 0);
        set_tree(5, 1, 1, 1, 1);
        send_route(0, 0);
        set_tree(2, 4, 0, 1, 1);   // zero size
        send_route(0, 1);
        set_tree(2, 65535, 65535, 1, 1);  // too many routers
        send_route(0, 1);
        set_tree(1, 65535, 1, 1, 1);
        send_route(65534, 0);
        send_route(16'h5555, 16'haaaa);
        set_tree(2, 65534, 2, 1, 1);      // exactly 2^16 routers
        send_route(65535, 65534);
        send_route(0, 65535);
        send_route(32767, 65534);
        set_tree(4, 32768, 16384, 8192, 8192);
        send_route(16'h8000, 16'h7fff);

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin sender_idle_pct = 61; receiver_idle_pct = 31; end
            if (ph == 2) begin sender_idle_pct = 0; receiver_idle_pct = 0; end
            for (int k = 0; k < 8; k++) begin
                random_tree();
                random_batch(57);
            end
        end

        // Back pressure: the receiver holds off while the sender keeps going.
        set_tree(3, 60, 12, 3, 1);
        fork
            begin
                sink_hold = 1;
                repeat (2000) @(negedge aclk);
                sink_hold = 0;
            end
            random_batch(20);
        join
        drain_hops();
        set_tree(4, 48, 24, 6, 2);
        random_batch(40);

        drain_hops();
        if (fail_count == 0) $display("tree_network_next_hop regression: pass");
        else $display("tree_network_next_hop regression: fail");
        $finish;
    end

endmodule
